// ===== hdl/zero_cross_burst_dimmer_macros.svh =====
// Assertion macros shared by the dimmer RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef ZERO_CROSS_BURST_DIMMER_MACROS_SVH
`define ZERO_CROSS_BURST_DIMMER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ZCBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ZCBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/zcbd_pkg.sv =====
// Shared types, constants and the threshold table for the burst-fire dimmer.
// No dependencies.
package zcbd_pkg;

  localparam int          GATE_BITS      = 10;
  localparam int          TABLE_LEN      = 24;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd425;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  channel;
    logic [7:0]  level;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [GATE_BITS-1:0] gate_pattern;
    logic [4:0]           step_used;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic       is_edge;
    logic [3:0] channel;
    logic [7:0] level;
  } cmd_t;

  // Threshold per step; steps past the table end use the last entry.
  function automatic logic [7:0] threshold_at(input logic [4:0] step);
    logic [7:0] thr;
    begin
      case (step)
        5'd0:    thr = 8'h00;
        5'd1:    thr = 8'h14;
        5'd2:    thr = 8'h1F;
        5'd3:    thr = 8'h29;
        5'd4:    thr = 8'h33;
        5'd5:    thr = 8'h3D;
        5'd6:    thr = 8'h48;
        5'd7:    thr = 8'h52;
        5'd8:    thr = 8'h5C;
        5'd9:    thr = 8'h66;
        5'd10:   thr = 8'h71;
        5'd11:   thr = 8'h7B;
        5'd12:   thr = 8'h85;
        5'd13:   thr = 8'h8F;
        5'd14:   thr = 8'h9A;
        5'd15:   thr = 8'hA4;
        5'd16:   thr = 8'hAE;
        5'd17:   thr = 8'hB8;
        5'd18:   thr = 8'hC3;
        5'd19:   thr = 8'hCD;
        5'd20:   thr = 8'hD7;
        5'd21:   thr = 8'hE1;
        5'd22:   thr = 8'hEC;
        default: thr = 8'hF6;
      endcase
      return thr;
    end
  endfunction

endpackage

// ===== hdl/zcbd_fifo.sv =====
// Small register-based queue; full and empty are decoded from a registered count.
// Generic; no package dependencies.
module zcbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/zcbd_front.sv =====
// Front end: accepts input words, debounces edges, drops ignored words.
// Depends on zcbd_pkg.
module zcbd_front
  import zcbd_pkg::*;
#(
  parameter int NUM_CHANNELS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        debounce_we,
  input  logic [15:0] debounce_data,
  input  logic        accept,
  input  in_item_t    item,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [15:0] debounce_us;
  logic [31:0] last_edge_time;
  logic        timer_armed;
  logic [31:0] elapsed;
  logic        chan_ok;
  logic        edge_ok;

  assign elapsed = item.time_us - last_edge_time;
  assign chan_ok = ({1'b0, item.channel} < 5'(NUM_CHANNELS));
  assign edge_ok = timer_armed && (elapsed >= {16'd0, debounce_us});

  always_comb begin
    if (item.action == ACT_WRITE) begin
      cmd_push = accept && chan_ok;
    end else begin
      cmd_push = accept && edge_ok;
    end
    cmd.is_edge = (item.action == ACT_EDGE);
    cmd.channel = item.channel;
    cmd.level   = item.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us    <= DEBOUNCE_RESET;
      last_edge_time <= '0;
      timer_armed    <= 1'b0;
    end else begin
      if (debounce_we) begin
        debounce_us <= debounce_data;
      end
      // First edge only arms; later edges restart the window when accepted.
      if (accept && item.action == ACT_EDGE && (!timer_armed || edge_ok)) begin
        last_edge_time <= item.time_us;
        timer_armed    <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/zcbd_back.sv =====
// Back end: applies level writes, builds gate patterns, advances the step.
// Depends on zcbd_pkg and the assertion macro header.
`include "zero_cross_burst_dimmer_macros.svh"
module zcbd_back
  import zcbd_pkg::*;
#(
  parameter int NUM_CHANNELS = 10,
  parameter int NUM_STEPS    = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_word
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [7:0]           levels [NUM_CHANNELS];
  logic [4:0]           step_index;
  logic [4:0]           step_index_next;
  logic [7:0]           thr;
  logic [GATE_BITS-1:0] pattern;

  assign thr = threshold_at(step_index);

  // Channels that do not exist stay at 1 (not conducting).
  for (genvar i = 0; i < GATE_BITS; i++) begin : g_cmp
    if (i < NUM_CHANNELS) begin : g_on
      assign pattern[i] = !(levels[i] >= thr);
    end else begin : g_off
      assign pattern[i] = 1'b1;
    end
  end

  always_comb begin
    cmd_pop  = 1'b0;
    out_push = 1'b0;
    if (!cmd_empty) begin
      if (cmd.is_edge) begin
        cmd_pop  = !out_full;
        out_push = !out_full;
      end else begin
        cmd_pop = 1'b1;
      end
    end
    out_word.gate_pattern = pattern;
    out_word.step_used    = step_index;
    step_index_next = (step_index == 5'(NUM_STEPS - 1)) ? 5'd0 : step_index + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        levels[i] <= '0;
      end
      step_index <= '0;
    end else begin
      if (cmd_pop && !cmd.is_edge) begin
        levels[cmd.channel[CW-1:0]] <= cmd.level;
      end
      if (out_push) begin
        step_index <= step_index_next;
      end
    end
  end

  `ZCBD_ASSERT_ALWAYS(a_step_range, 6'(step_index) < 6'(NUM_STEPS), "step index out of range")
  `ZCBD_ASSERT_IMPLY(a_edge_emits, cmd_pop && cmd.is_edge, out_push,
                     "edge command dropped without a result")
  `ZCBD_ASSERT_IMPLY(a_push_is_edge, out_push, cmd_pop && cmd.is_edge && !cmd_empty,
                     "result pushed without an edge command")

endmodule

// ===== hdl/zero_cross_burst_dimmer.sv =====
// Top level of the burst-fire zero-cross dimmer.
// Depends on zcbd_pkg, zcbd_front, zcbd_back and zcbd_fifo.

// Cycle-skipping AC dimmer for up to ten lamp channels (ten by default),
// with a gate pattern of ten active-low bits. Push input words: action 0
// stores a channel level (writes to missing channels are dropped), action 1
// is a zero-crossing edge with a microsecond timestamp. The first edge after
// reset only arms the timer; an edge less than debounce_us after the last
// accepted edge is dropped. Each accepted edge yields one result word: bit i
// of gate_pattern is low when channel i's level is at least the threshold of
// the current table step, and step_used names that step, which then advances
// modulo NUM_STEPS. The block takes one word per clock while the command
// queue has room. A result passes through the command queue between the
// debounce front end and the pattern back end, then through the four-entry
// result queue, before it appears on the result ports. full rises only when
// the four-entry command queue backs up behind a result queue that is not
// being popped. Write debounce_us through debounce_we/debounce_data only
// while the block is idle; it resets to 425.
module zero_cross_burst_dimmer
  import zcbd_pkg::*;
#(
  parameter int NUM_CHANNELS = 10,
  parameter int NUM_STEPS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        debounce_we,
  input  logic [15:0] debounce_data,
  input  logic        push,
  output logic        full,
  input  in_item_t    item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result
);

  localparam int QUEUE_DEPTH = 4;

  logic      accept;
  logic      cmd_push;
  cmd_t      cmd_in;
  cmd_t      cmd_head;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      out_full;
  logic      out_push;
  out_item_t out_word;

  // Take a word whenever the command queue has room; dropped words still
  // count as taken.
  assign accept = push && !cmd_full;
  assign full   = cmd_full;

  zcbd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .debounce_we  (debounce_we),
    .debounce_data(debounce_data),
    .accept       (accept),
    .item         (item),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  // Decouple front and back so each can stall on its own.
  zcbd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  zcbd_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .NUM_STEPS   (NUM_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_word (out_word)
  );

  // Hold finished results until the consumer pops them.
  zcbd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_word),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule
